### rtl/lfdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfdc_pkg: shared types and constants for the line follower drive control
// Mode codes, motor command codes, register indexes and the structs that
// pass between the top level and the tick logic.
// ----------------------------------------------------------------------------
package lfdc_pkg;

   localparam int unsigned CNT_W   = 16;
   localparam int unsigned DRV_W   = 2;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned CSR_A_W = 2;
   localparam int unsigned CSR_D_W = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_A_W-1:0] CSR_PERIOD_LIMIT = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_RUN_TIME     = 2'd1;

   localparam logic [CNT_W-1:0] PERIOD_LIMIT_RESET = 16'd200;
   localparam logic [CNT_W-1:0] RUN_TIME_RESET     = 16'd150;
   localparam logic [CNT_W-1:0] CURRENT_RUN_RESET  = 16'd200;

   // Motor commands.
   localparam logic [DRV_W-1:0] DRV_STOP = 2'd0;
   localparam logic [DRV_W-1:0] DRV_FWD  = 2'd1;
   localparam logic [DRV_W-1:0] DRV_BACK = 2'd2;

   // Mode codes as they appear on the result word.
   localparam logic [MODE_W-1:0] MODE_CODE_FWD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_LEFT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_RIGHT = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CODE_STOP  = 2'd3;

   typedef enum logic [3:0] {
      MODE_FWD   = 4'b0001,
      MODE_LEFT  = 4'b0010,
      MODE_RIGHT = 4'b0100,
      MODE_STOP  = 4'b1000
   } mode_type;

   typedef struct packed {
      logic outer_left;
      logic mid_left;
      logic mid_right;
      logic outer_right;
   } sensor_type;

   typedef struct packed {
      mode_type         mode;
      logic [CNT_W-1:0] period_count;
      logic [CNT_W-1:0] current_run;
   } ctl_state_type;

   typedef struct packed {
      logic [DRV_W-1:0]  left_drive;
      logic [DRV_W-1:0]  right_drive;
      logic [MODE_W-1:0] mode;
   } result_type;

endpackage

`default_nettype wire

### rtl/line_follower_drive_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_follower_drive_control: line follower motor control
// Steps a four-mode steering machine on each sensor word and issues left and
// right motor commands gated by a period counter and a run-time window.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  req     | req_valid/req_stall  | outer_left, mid_left, mid_right, outer_right
//  rsp     | rsp_valid/rsp_stall  | left_drive, right_drive, mode
//  csr     | csr_valid/csr_ready  | csr_index, csr_wdata
//
// A word passes from acceptance to result through the input register and then
// the result register. One word is accepted in every cycle while the result
// side keeps taking them. Reset (synchronous) empties both stages and
// loads the registers and state with their defaults. A stall on the result
// side holds the result word; the input register can still take one word, and
// req_stall is high in every cycle in which that register is full and stuck.
// ----------------------------------------------------------------------------
module line_follower_drive_control (
   input  wire  logic                              clock,
   input  wire  logic                              reset,
   input  wire  logic                              req_valid,
   output       logic                              req_stall,
   input  wire  logic                              req_outer_left,
   input  wire  logic                              req_mid_left,
   input  wire  logic                              req_mid_right,
   input  wire  logic                              req_outer_right,
   output       logic                              rsp_valid,
   input  wire  logic                              rsp_stall,
   output       logic [lfdc_pkg::DRV_W-1:0]        rsp_left_drive,
   output       logic [lfdc_pkg::DRV_W-1:0]        rsp_right_drive,
   output       logic [lfdc_pkg::MODE_W-1:0]       rsp_mode,
   input  wire  logic                              csr_valid,
   output       logic                              csr_ready,
   input  wire  logic [lfdc_pkg::CSR_A_W-1:0]      csr_index,
   input  wire  logic [lfdc_pkg::CSR_D_W-1:0]      csr_wdata
);

   logic                       in_valid_ff, in_valid_in;
   lfdc_pkg::sensor_type       in_sensor_ff;
   logic                       out_valid_ff, out_valid_in;
   lfdc_pkg::result_type       out_result_ff;
   lfdc_pkg::ctl_state_type    state_ff, state_tick;
   lfdc_pkg::result_type       result_tick;
   logic [lfdc_pkg::CNT_W-1:0] period_limit_ff;
   logic [lfdc_pkg::CNT_W-1:0] run_time_ff;
   logic                       out_free, in_move, req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_move   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !in_move);
   assign out_valid_in = in_move || (out_valid_ff && rsp_stall);

   assign csr_ready = 1'b1;

   lfdc_tick u_tick (
      .sensor       (in_sensor_ff),
      .state_cur    (state_ff),
      .period_limit (period_limit_ff),
      .run_time     (run_time_ff),
      .state_nxt    (state_tick),
      .result       (result_tick)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
         state_ff.mode            <= lfdc_pkg::MODE_FWD;
         state_ff.period_count    <= '0;
         state_ff.current_run     <= lfdc_pkg::CURRENT_RUN_RESET;
         period_limit_ff          <= lfdc_pkg::PERIOD_LIMIT_RESET;
         run_time_ff              <= lfdc_pkg::RUN_TIME_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_move) begin
            state_ff <= state_tick;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lfdc_pkg::CSR_PERIOD_LIMIT: period_limit_ff <= csr_wdata;
               lfdc_pkg::CSR_RUN_TIME:     run_time_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sensor_ff.outer_left  <= req_outer_left;
         in_sensor_ff.mid_left    <= req_mid_left;
         in_sensor_ff.mid_right   <= req_mid_right;
         in_sensor_ff.outer_right <= req_outer_right;
      end
      if (in_move) begin
         out_result_ff <= result_tick;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_left_drive  = out_result_ff.left_drive;
   assign rsp_right_drive = out_result_ff.right_drive;
   assign rsp_mode        = out_result_ff.mode;

endmodule

`default_nettype wire

### rtl/lfdc_tick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfdc_tick: next state and motor commands for one control tick
// Advances the period counter, steps the mode machine on the sensor pattern
// and derives both motor commands from the new mode.
// ----------------------------------------------------------------------------
module lfdc_tick (
   input  wire  lfdc_pkg::sensor_type            sensor,
   input  wire  lfdc_pkg::ctl_state_type         state_cur,
   input  wire  logic [lfdc_pkg::CNT_W-1:0]      period_limit,
   input  wire  logic [lfdc_pkg::CNT_W-1:0]      run_time,
   output lfdc_pkg::ctl_state_type               state_nxt,
   output lfdc_pkg::result_type                  result
);

   logic [lfdc_pkg::CNT_W-1:0] cnt_inc;
   logic [lfdc_pkg::CNT_W-1:0] cnt_nxt;
   logic [lfdc_pkg::CNT_W-1:0] run_nxt;
   lfdc_pkg::mode_type         mode_nxt;
   logic l, ml, mr, r;

   assign l  = sensor.outer_left;
   assign ml = sensor.mid_left;
   assign mr = sensor.mid_right;
   assign r  = sensor.outer_right;

   assign cnt_inc = state_cur.period_count + lfdc_pkg::CNT_W'(1);
   assign cnt_nxt = (cnt_inc > period_limit) ? '0 : cnt_inc;

   always_comb begin
      mode_nxt = state_cur.mode;
      run_nxt  = state_cur.current_run;
      case (state_cur.mode)
         lfdc_pkg::MODE_FWD: begin
            if (ml && mr) begin
               run_nxt = run_time;
               if (l && !r) begin
                  mode_nxt = lfdc_pkg::MODE_LEFT;
               end else if (!l && r) begin
                  mode_nxt = lfdc_pkg::MODE_RIGHT;
               end else begin
                  mode_nxt = lfdc_pkg::MODE_FWD;
               end
            end else if (ml) begin
               mode_nxt = (!l && r) ? lfdc_pkg::MODE_FWD : lfdc_pkg::MODE_LEFT;
            end else if (mr) begin
               mode_nxt = (l && !r) ? lfdc_pkg::MODE_FWD : lfdc_pkg::MODE_RIGHT;
            end else begin
               mode_nxt = (!l && !r) ? lfdc_pkg::MODE_STOP : lfdc_pkg::MODE_FWD;
            end
         end
         lfdc_pkg::MODE_LEFT, lfdc_pkg::MODE_RIGHT: begin
            run_nxt = run_time;
            if (ml && mr) begin
               mode_nxt = lfdc_pkg::MODE_FWD;
            end else if (ml) begin
               mode_nxt = lfdc_pkg::MODE_LEFT;
            end else if (mr) begin
               mode_nxt = lfdc_pkg::MODE_RIGHT;
            end
         end
         lfdc_pkg::MODE_STOP: begin
            mode_nxt = (ml && mr) ? lfdc_pkg::MODE_FWD : lfdc_pkg::MODE_STOP;
         end
         default: begin
            mode_nxt = lfdc_pkg::MODE_FWD;
         end
      endcase
   end

   // The drive window compares against the run time as it stands after the
   // transition, so a reload in this tick already counts.
   always_comb begin
      result.left_drive  = lfdc_pkg::DRV_STOP;
      result.right_drive = lfdc_pkg::DRV_STOP;
      result.mode        = lfdc_pkg::MODE_CODE_FWD;
      state_nxt.mode         = mode_nxt;
      state_nxt.period_count = cnt_nxt;
      state_nxt.current_run  = run_nxt;
      case (mode_nxt)
         lfdc_pkg::MODE_STOP: begin
            result.mode           = lfdc_pkg::MODE_CODE_STOP;
            state_nxt.current_run = run_time;
         end
         lfdc_pkg::MODE_FWD: begin
            result.mode = lfdc_pkg::MODE_CODE_FWD;
            if (cnt_nxt <= run_nxt) begin
               result.left_drive  = lfdc_pkg::DRV_BACK;
               result.right_drive = lfdc_pkg::DRV_BACK;
            end
         end
         lfdc_pkg::MODE_LEFT: begin
            result.mode = lfdc_pkg::MODE_CODE_LEFT;
            if (cnt_nxt <= run_nxt) begin
               result.left_drive  = lfdc_pkg::DRV_BACK;
               result.right_drive = lfdc_pkg::DRV_FWD;
            end
         end
         lfdc_pkg::MODE_RIGHT: begin
            result.mode = lfdc_pkg::MODE_CODE_RIGHT;
            if (cnt_nxt <= run_nxt) begin
               result.left_drive  = lfdc_pkg::DRV_FWD;
               result.right_drive = lfdc_pkg::DRV_BACK;
            end
         end
         default: begin
            result.mode = lfdc_pkg::MODE_CODE_FWD;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/lfdc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfdc_checker: port-level checks for the line follower drive control
// Watches the result channel for held words, an empty channel after reset and legal motor commands.
// ----------------------------------------------------------------------------
module lfdc_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire logic [lfdc_pkg::DRV_W-1:0]  rsp_left_drive,
   input wire logic [lfdc_pkg::DRV_W-1:0]  rsp_right_drive,
   input wire logic [lfdc_pkg::MODE_W-1:0] rsp_mode
);

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_drive)
         && $stable(rsp_right_drive) && $stable(rsp_mode))
      else $error("result word changed under stall");

   // No result may be left over after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Stop mode never drives a motor.
   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == lfdc_pkg::MODE_CODE_STOP |->
         rsp_left_drive == lfdc_pkg::DRV_STOP && rsp_right_drive == lfdc_pkg::DRV_STOP)
      else $error("motor driven in stop mode");

   // Going straight drives both motors alike.
   a_fwd_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == lfdc_pkg::MODE_CODE_FWD |->
         rsp_left_drive == rsp_right_drive)
      else $error("uneven drive in forward mode");

   // In a turn one motor runs forward and the other back, or both stop.
   a_turn_split: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == lfdc_pkg::MODE_CODE_LEFT
         || rsp_mode == lfdc_pkg::MODE_CODE_RIGHT) |->
         (rsp_left_drive == lfdc_pkg::DRV_STOP && rsp_right_drive == lfdc_pkg::DRV_STOP)
         || (rsp_left_drive != rsp_right_drive))
      else $error("turn drives motors alike");

endmodule

bind line_follower_drive_control lfdc_checker u_lfdc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_left_drive  (rsp_left_drive),
   .rsp_right_drive (rsp_right_drive),
   .rsp_mode        (rsp_mode)
);

`default_nettype wire
